FILE: hdl/rau_pkg.sv
// Package with shared types and operation and status codes for the rational arithmetic unit.
package rau_pkg;

    typedef logic [2:0] kind_t;
    typedef logic [1:0] status_t;

    // Operation codes carried in the kind field.
    localparam kind_t KIND_ADD = 3'd0;
    localparam kind_t KIND_SUB = 3'd1;
    localparam kind_t KIND_MUL = 3'd2;
    localparam kind_t KIND_DIV = 3'd3;
    localparam kind_t KIND_ABS = 3'd4;
    localparam kind_t KIND_RED = 3'd5;

    // Result status codes.
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_OVF  = 2'd1;
    localparam status_t ST_DIVZ = 2'd2;

endpackage

FILE: hdl/rau_if.sv
// Handshake interfaces for the operand and result channels of the rational arithmetic unit.
interface rau_in_if #(
    parameter int VALUE_WIDTH = 16
);
    import rau_pkg::*;

    logic                          valid;
    logic                          ready;
    kind_t                         kind;
    logic signed [VALUE_WIDTH-1:0] first_numerator;
    logic signed [VALUE_WIDTH-1:0] first_denominator;
    logic signed [VALUE_WIDTH-1:0] second_numerator;
    logic signed [VALUE_WIDTH-1:0] second_denominator;

    modport source (
        output valid, kind, first_numerator, first_denominator,
               second_numerator, second_denominator,
        input  ready
    );

    modport sink (
        input  valid, kind, first_numerator, first_denominator,
               second_numerator, second_denominator,
        output ready
    );
endinterface

interface rau_out_if #(
    parameter int VALUE_WIDTH = 16
);
    import rau_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] result_numerator;
    logic signed [VALUE_WIDTH-1:0] result_denominator;
    status_t                       status;

    modport source (
        output valid, result_numerator, result_denominator, status,
        input  ready
    );

    modport sink (
        input  valid, result_numerator, result_denominator, status,
        output ready
    );
endinterface

FILE: hdl/rau_mul.sv
// Registered signed multiplier shared by all product steps of the unit.
module rau_mul #(
    parameter int WIDTH = 16
) (
    input  logic                        clk,
    input  logic signed [WIDTH-1:0]     a,
    input  logic signed [WIDTH-1:0]     b,
    output logic signed [2*WIDTH-1:0]   product
);
    logic signed [2*WIDTH-1:0] product_reg;

    // One full-width product per cycle, registered.
    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;
endmodule

FILE: hdl/rau_gcd.sv
// Iterative binary gcd unit: one shift or one subtract and compare per cycle.
module rau_gcd #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             done,
    output logic [WIDTH-1:0] gcd
);
    localparam int KW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [WIDTH-1:0] g_reg, g_next;

    // Step of Stein's algorithm; the common power of two is restored at the end.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0)
            begin
                g_next    = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (b_reg == '0)
            begin
                g_next    = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = a_reg - b_reg;
            end
            else
            begin
                b_next = b_reg - a_reg;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working values.
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign done = done_reg;
    assign gcd  = g_reg;
endmodule

FILE: hdl/rau_div.sv
// Restoring unsigned divider: one quotient bit per cycle.
module rau_div #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);
    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[WIDTH-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working values.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: hdl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: sequencer around a shared multiplier, gcd and divider.
//
//   channel   direction  word contents
//   operand   in         kind, first and second numerator and denominator
//   result    out        result numerator, result denominator, status
//
// One word is worked on at a time; operand.ready is high only while the sequencer is idle.
// Add and subtract pass through S_M1 to S_M4 and S_FIN to the output register, multiply
// through S_M1 to S_M3 and S_FIN, divide through S_M1 to S_M3, S_NORM and S_FIN, absolute
// value and unknown kinds straight to S_FIN; these steps are set by the three or two
// passes through the registered multiplier. Reduce takes the binary gcd loop (one shift
// or subtract per cycle) plus two passes through the restoring divider, then S_NORM, S_FIN.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A result waits in the output register while result.ready is low; the next word is
// accepted meanwhile and its finished result waits in the final state.
module rational_arithmetic_unit_top #(
    parameter int VALUE_WIDTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    rau_in_if.sink    operand,
    rau_out_if.source result
);
    import rau_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int RW = 2 * VALUE_WIDTH + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_M4   = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIV1 = 4'd6;
    localparam logic [3:0] S_DIV2 = 4'd7;
    localparam logic [3:0] S_NORM = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic signed [W-1:0] sgn(input logic signed [W-1:0] x);
        logic signed [W-1:0] s;
        if (x == '0)
        begin
            s = '0;
        end
        else if (x[W-1])
        begin
            s = '1;
        end
        else
        begin
            s = {{(W-1){1'b0}}, 1'b1};
        end
        return s;
    endfunction

    function automatic logic fits(input logic signed [RW-1:0] v);
        return v[RW-1:W-1] == {(RW-W+1){v[W-1]}};
    endfunction

    logic [3:0]           state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic signed [W-1:0]  oa_reg, oa_next;
    logic signed [W-1:0]  ob_reg, ob_next;
    logic signed [W-1:0]  oc_reg, oc_next;
    logic signed [W-1:0]  od_reg, od_next;
    logic signed [PW-1:0] p1_reg, p1_next;
    logic signed [PW-1:0] p2_reg, p2_next;
    logic signed [RW-1:0] rn_reg, rn_next;
    logic signed [RW-1:0] rd_reg, rd_next;
    logic                 divz_reg, divz_next;
    logic                 res_valid_reg, res_valid_next;
    logic signed [W-1:0]  res_num_reg, res_num_next;
    logic signed [W-1:0]  res_den_reg, res_den_next;
    status_t              res_status_reg, res_status_next;

    logic signed [W-1:0]  x1, y1, x2, y2;
    logic                 cancel1, cancel2;
    logic signed [W-1:0]  ca, cb, cc, cd;
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [RW-1:0] sum;
    logic                 gcd_start, gcd_done;
    logic [W-1:0]         gcd_g;
    logic                 div_start, div_done;
    logic [W-1:0]         div_dividend, div_q;

    // Shared registered multiplier.
    rau_mul #(.WIDTH(W)) u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // Iterative gcd of the reduce operand magnitudes.
    rau_gcd #(.WIDTH(W)) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a     (mag(operand.first_numerator)),
        .b     (mag(operand.first_denominator)),
        .done  (gcd_done),
        .gcd   (gcd_g)
    );

    // Divider shared by numerator and denominator of reduce.
    rau_div #(.WIDTH(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_q)
    );

    // Cross cancellation for multiply and divide; divide uses the reciprocal of the second operand.
    always_comb
    begin
        x1 = operand.first_numerator;
        x2 = operand.first_denominator;
        if (operand.kind == KIND_DIV)
        begin
            y1 = operand.second_denominator;
            y2 = operand.second_numerator;
        end
        else
        begin
            y1 = operand.second_numerator;
            y2 = operand.second_denominator;
        end
        cancel1 = mag(x1) == mag(y2);
        cancel2 = mag(y1) == mag(x2);
        ca = cancel1 ? sgn(x1) : x1;
        cd = cancel1 ? sgn(y2) : y2;
        cb = cancel2 ? sgn(y1) : y1;
        cc = cancel2 ? sgn(x2) : x2;
    end

    // Multiplier operand selection by step.
    always_comb
    begin
        case (state_reg)
            S_M1:
            begin
                mul_a = oa_reg;
                mul_b = ob_reg;
            end
            S_M2:
            begin
                mul_a = oc_reg;
                mul_b = od_reg;
            end
            default:
            begin
                mul_a = od_reg;
                mul_b = ob_reg;
            end
        endcase
    end

    assign div_dividend = (state_reg == S_GCD) ? mag(oa_reg) : mag(od_reg);

    // Cross-multiplied sum for add and subtract.
    assign sum = (kind_reg == KIND_SUB) ? (RW'(p1_reg) - RW'(p2_reg))
                                        : (RW'(p1_reg) + RW'(p2_reg));

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        oa_next         = oa_reg;
        ob_next         = ob_reg;
        oc_next         = oc_reg;
        od_next         = od_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        rn_next         = rn_reg;
        rd_next         = rd_reg;
        divz_next       = divz_reg;
        res_num_next    = res_num_reg;
        res_den_next    = res_den_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        gcd_start       = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (operand.valid)
                begin
                    kind_next = operand.kind;
                    divz_next = 1'b0;
                    oa_next   = operand.first_numerator;
                    ob_next   = operand.second_denominator;
                    oc_next   = operand.second_numerator;
                    od_next   = operand.first_denominator;
                    case (operand.kind)
                        KIND_ADD, KIND_SUB:
                        begin
                            state_next = S_M1;
                        end
                        KIND_MUL, KIND_DIV:
                        begin
                            oa_next = ca;
                            ob_next = cb;
                            oc_next = cc;
                            od_next = cd;
                            if (operand.kind == KIND_DIV && operand.second_numerator == '0)
                            begin
                                divz_next  = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_M1;
                            end
                        end
                        KIND_ABS:
                        begin
                            rn_next    = RW'(mag(operand.first_numerator));
                            rd_next    = RW'(mag(operand.first_denominator));
                            state_next = S_FIN;
                        end
                        KIND_RED:
                        begin
                            if (operand.first_numerator == '0 &&
                                operand.first_denominator == '0)
                            begin
                                divz_next  = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                gcd_start  = 1'b1;
                                state_next = S_GCD;
                            end
                        end
                        default:
                        begin
                            rn_next    = RW'(operand.first_numerator);
                            rd_next    = RW'(operand.first_denominator);
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_M1:
            begin
                state_next = S_M2;
            end
            S_M2:
            begin
                p1_next    = mul_p;
                state_next = S_M3;
            end
            S_M3:
            begin
                if (kind_reg == KIND_ADD || kind_reg == KIND_SUB)
                begin
                    p2_next    = mul_p;
                    state_next = S_M4;
                end
                else
                begin
                    // A zero numerator forces the denominator to one.
                    rn_next    = RW'(p1_reg);
                    rd_next    = (p1_reg == '0) ? RW'(1) : RW'(mul_p);
                    state_next = (kind_reg == KIND_DIV) ? S_NORM : S_FIN;
                end
            end
            S_M4:
            begin
                rn_next    = sum;
                rd_next    = (sum == '0) ? RW'(1) : RW'(mul_p);
                state_next = S_FIN;
            end
            S_GCD:
            begin
                if (gcd_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    rn_next    = oa_reg[W-1] ? (RW'(0) - RW'(div_q)) : RW'(div_q);
                    div_start  = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    rd_next    = od_reg[W-1] ? (RW'(0) - RW'(div_q)) : RW'(div_q);
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // Move the sign to the numerator.
                if (rd_reg[RW-1])
                begin
                    rn_next = -rn_reg;
                    rd_next = -rd_reg;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    if (divz_reg)
                    begin
                        res_num_next    = '0;
                        res_den_next    = '0;
                        res_status_next = ST_DIVZ;
                    end
                    else
                    begin
                        res_num_next    = rn_reg[W-1:0];
                        res_den_next    = rd_reg[W-1:0];
                        res_status_next = (fits(rn_reg) && fits(rd_reg)) ? ST_OK : ST_OVF;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Operands, partial products and result words.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        oa_reg         <= oa_next;
        ob_reg         <= ob_next;
        oc_reg         <= oc_next;
        od_reg         <= od_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        rn_reg         <= rn_next;
        rd_reg         <= rd_next;
        divz_reg       <= divz_next;
        res_num_reg    <= res_num_next;
        res_den_reg    <= res_den_next;
        res_status_reg <= res_status_next;
    end

    assign operand.ready             = (state_reg == S_IDLE);
    assign result.valid              = res_valid_reg;
    assign result.result_numerator   = res_num_reg;
    assign result.result_denominator = res_den_reg;
    assign result.status             = res_status_reg;
endmodule
